// ===== src/clkbr_pkg.sv =====
// ----------------------------------------------------------------------------
// clkbr_pkg
// Shared types and codes for the clock display brightness controller.
// ----------------------------------------------------------------------------
package clkbr_pkg;

  // Event codes
  localparam logic [2:0] OP_MINUTE = 3'd0;
  localparam logic [2:0] OP_BLINK  = 3'd1;
  localparam logic [2:0] OP_LIGHT  = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_LAMP   = 3'd4;

  // Display commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_BLANK = 3'd1;
  localparam logic [2:0] CMD_ON    = 3'd2;
  localparam logic [2:0] CMD_OFF   = 3'd3;
  localparam logic [2:0] CMD_ALL   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_AMB_LO    = 2'd0;
  localparam logic [1:0] REG_AMB_HI    = 2'd1;
  localparam logic [1:0] REG_AMB_STEP  = 2'd2;
  localparam logic [1:0] REG_AMB_FLOOR = 2'd3;

  // Shared divider widths: (sample - low) * 100 over a 10-bit span
  localparam int DIV_NUM_W = 17;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [6:0] PCT_MIN = 7'd1;
  localparam logic [6:0] PCT_MAX = 7'd100;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] light_sample;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
  } in_t;

  typedef struct packed {
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [2:0] display_cmd;
    logic [6:0] brightness;
    logic       brightness_new;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [9:0] amb_lo;
    logic [9:0] amb_hi;
    logic [6:0] amb_step;
    logic [6:0] amb_floor;
  } cfg_t;

endpackage

// ===== src/clkbr_div.sv =====
// ----------------------------------------------------------------------------
// clkbr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clkbr_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [clkbr_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [clkbr_pkg::DIV_DEN_W-1:0]    den_i,
  output logic                               done_o,
  output logic [clkbr_pkg::DIV_NUM_W-1:0]    quot_o
);
  import clkbr_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LastCnt = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_NUM_W-1]};
    fits   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // trial - den fits in the remainder width whenever the subtract happens
      rem_d = fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/clkbr_light.sv =====
// ----------------------------------------------------------------------------
// clkbr_light
// Light sample to brightness sequencer around the shared divider.
// ----------------------------------------------------------------------------
module clkbr_light (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [9:0]        sample_i,
  input  clkbr_pkg::cfg_t   cfg_i,
  output logic              done_o,
  output logic              issued_o,
  output logic [6:0]        brightness_o
);
  import clkbr_pkg::*;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_DIV1  = 3'd1;
  localparam logic [2:0] L_CHECK = 3'd2;
  localparam logic [2:0] L_DIV2  = 3'd3;
  localparam logic [2:0] L_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [6:0] pct_q, pct_d;
  logic [6:0] last_q, last_d;
  logic [6:0] bright_q, bright_d;
  logic       issued_q, issued_d;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic [9:0]  span;
  logic [9:0]  diff;
  logic [6:0]  step_eff;
  logic [6:0]  half;
  logic [6:0]  floor_eff;
  logic        take;
  logic [15:0] rounded;
  logic [6:0]  round_sat;

  clkbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    span      = cfg_i.amb_hi - cfg_i.amb_lo;
    diff      = sample_i - cfg_i.amb_lo;
    step_eff  = (cfg_i.amb_step == 7'd0) ? 7'd1 : cfg_i.amb_step;
    half      = step_eff >> 1;
    if (cfg_i.amb_floor == 7'd0) begin
      floor_eff = PCT_MIN;
    end else if (cfg_i.amb_floor > PCT_MAX) begin
      floor_eff = PCT_MAX;
    end else begin
      floor_eff = cfg_i.amb_floor;
    end
    // accept only a real change past half a step, or an end of the range
    take = (pct_q != last_q) &&
           (({1'b0, pct_q} > ({1'b0, last_q} + {1'b0, half})) ||
            (({1'b0, pct_q} + {1'b0, half}) < {1'b0, last_q}) ||
            (pct_q == PCT_MIN) || (pct_q == PCT_MAX));
    rounded   = {8'd0, div_quot[7:0]} * {9'd0, step_eff};
    if (rounded > 16'(PCT_MAX)) begin
      round_sat = PCT_MAX;
    end else begin
      round_sat = rounded[6:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    pct_d     = pct_q;
    last_d    = last_q;
    bright_d  = bright_q;
    issued_d  = issued_q;
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(diff) * DIV_NUM_W'(100);
    div_den   = span;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          if (sample_i < cfg_i.amb_lo) begin
            pct_d   = PCT_MIN;
            state_d = L_CHECK;
          end else if ((sample_i > cfg_i.amb_hi) || (span == 10'd0)) begin
            pct_d   = PCT_MAX;
            state_d = L_CHECK;
          end else begin
            div_start = 1'b1;
            state_d   = L_DIV1;
          end
        end
      end
      L_DIV1: begin
        if (div_done) begin
          pct_d   = div_quot[6:0];
          state_d = L_CHECK;
        end
      end
      L_CHECK: begin
        div_num = DIV_NUM_W'(pct_q) + DIV_NUM_W'(half);
        div_den = DIV_DEN_W'(step_eff);
        if (!take) begin
          issued_d = 1'b0;
          state_d  = L_FIN;
        end else begin
          last_d   = pct_q;
          issued_d = 1'b1;
          if (pct_q == PCT_MAX) begin
            bright_d = PCT_MAX;
            state_d  = L_FIN;
          end else begin
            div_start = 1'b1;
            state_d   = L_DIV2;
          end
        end
      end
      L_DIV2: begin
        if (div_done) begin
          bright_d = (round_sat < floor_eff) ? floor_eff : round_sat;
          state_d  = L_FIN;
        end
      end
      L_FIN: begin
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      last_q   <= 7'd0;
      bright_q <= PCT_MAX;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      bright_q <= bright_d;
      issued_q <= issued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pct_q <= pct_d;
  end

  assign done_o       = (state_q == L_FIN);
  assign issued_o     = issued_q;
  assign brightness_o = bright_q;

endmodule

// ===== src/clock_display_brightness_ctrl_top.sv =====
// ----------------------------------------------------------------------------
// clock_display_brightness_ctrl_top
// Event-driven clock display controller with ambient-light brightness.
// ----------------------------------------------------------------------------
// One request is handled at a time. Minute tick, blink tick, set time and
// unused codes produce their single response in the cycle after the request
// is taken; lamp test produces two responses back to back as the sink takes
// them. A light sample runs through one shared restoring divider, one
// quotient bit per cycle: once for the percent and, when a value below 100
// percent is accepted, once more for rounding to the step. A sample outside
// the range or over a zero span skips the first division. With the sink
// ready the next request is taken once the sink has taken the response and
// the response valid register has cleared. The request channel stalls while
// a request is in progress or a response waits for the sink. Configuration
// writes land at once.
// ----------------------------------------------------------------------------
module clock_display_brightness_ctrl_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clkbr_pkg::in_t    in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output clkbr_pkg::out_t   out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [9:0]        cfg_data_i
);
  import clkbr_pkg::*;

  // Keep only the converter bits that the sample path really has
  localparam int MaskBits = (SAMPLE_BITS < 10) ? SAMPLE_BITS : 10;
  localparam logic [9:0] SampleMask = 10'((32'd1 << MaskBits) - 32'd1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LIGHT = 2'd1;
  localparam logic [1:0] ST_LAMP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic       valid_q, valid_d;
  logic       blink_q, blink_d;
  cfg_t       cfg_q;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  logic       in_take;
  logic       out_take;
  logic       light_start;
  logic       light_done;
  logic       light_issued;
  logic [6:0] light_bright;
  logic [9:0] sample_m;

  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign sample_m    = in_req_i.light_sample & SampleMask;
  assign light_start = in_take && (in_req_i.op == OP_LIGHT);

  clkbr_light u_light (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (light_start),
    .sample_i     (sample_m),
    .cfg_i        (cfg_q),
    .done_o       (light_done),
    .issued_o     (light_issued),
    .brightness_o (light_bright)
  );

  // Refresh command from the blink phase after this event
  function automatic logic [2:0] refresh_cmd(input logic tvalid, input logic phase);
    logic [2:0] cmd;
    if (phase) begin
      cmd = CMD_ON;
    end else if (tvalid) begin
      cmd = CMD_OFF;
    end else begin
      cmd = CMD_BLANK;
    end
    return cmd;
  endfunction

  always_comb begin
    state_d     = state_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    valid_d     = valid_q;
    blink_d     = blink_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // Drop the response once the sink takes it
    if (out_take) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          out_valid_d = 1'b1;
          case (in_req_i.op)
            OP_MINUTE: begin
              if (minute_q == 6'd59) begin
                minute_d = 6'd0;
                hour_d   = (hour_q == 5'd23) ? 5'd0 : hour_q + 5'd1;
              end else begin
                minute_d = minute_q + 6'd1;
              end
              out_d.display_cmd = CMD_NONE;
            end
            OP_BLINK: begin
              blink_d           = !blink_q;
              out_d.display_cmd = refresh_cmd(valid_q, !blink_q);
            end
            OP_LIGHT: begin
              // Hold the response until the light sequencer finishes
              out_valid_d = 1'b0;
              state_d     = ST_LIGHT;
            end
            OP_SET: begin
              hour_d   = (in_req_i.new_hour > 5'd23) ? 5'd23 : in_req_i.new_hour;
              minute_d = (in_req_i.new_minute > 6'd59) ? 6'd59 : in_req_i.new_minute;
              valid_d  = 1'b1;
              blink_d  = 1'b1;
              out_d.display_cmd = CMD_ON;
            end
            OP_LAMP: begin
              blink_d           = 1'b1;
              out_d.display_cmd = CMD_ALL;
              state_d           = ST_LAMP;
            end
            default: begin
              out_d.display_cmd = CMD_NONE;
            end
          endcase
          out_d.hour_now       = hour_d;
          out_d.minute_now     = minute_d;
          out_d.brightness     = light_bright;
          out_d.brightness_new = 1'b0;
          out_d.last           = (in_req_i.op != OP_LAMP);
        end
      end
      ST_LIGHT: begin
        if (light_done) begin
          out_valid_d          = 1'b1;
          out_d.hour_now       = hour_q;
          out_d.minute_now     = minute_q;
          out_d.display_cmd    = CMD_NONE;
          out_d.brightness     = light_bright;
          out_d.brightness_new = light_issued;
          out_d.last           = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      ST_LAMP: begin
        // Advance to the refresh once the all-segments response is taken
        if (out_take) begin
          out_valid_d       = 1'b1;
          out_d.display_cmd = refresh_cmd(valid_q, blink_q);
          out_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hour_q      <= 5'd0;
      minute_q    <= 6'd0;
      valid_q     <= 1'b0;
      blink_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      valid_q     <= valid_d;
      blink_q     <= blink_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amb_lo    <= 10'd500;
      cfg_q.amb_hi    <= 10'd900;
      cfg_q.amb_step  <= 7'd30;
      cfg_q.amb_floor <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_AMB_LO:    cfg_q.amb_lo    <= cfg_data_i;
        REG_AMB_HI:    cfg_q.amb_hi    <= cfg_data_i;
        REG_AMB_STEP:  cfg_q.amb_step  <= cfg_data_i[6:0];
        REG_AMB_FLOOR: cfg_q.amb_floor <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
